FILE: src/dpp_pkg.sv
package dpp_pkg;

  // Frame geometry.
  localparam int FRAME_WIDTH  = 640;
  localparam int FRAME_HEIGHT = 480;

  // Field widths.
  localparam int DISP_W = 11;
  localparam int COL_W  = 10;
  localparam int ROW_W  = 9;
  localparam int FOV_W  = 20;
  localparam int Z_W    = 16;
  localparam int POS_W  = 17;

  // Coordinates compared against frame limits, wide enough for this frame size.
  localparam int COORD_W = 13;
  localparam logic [COORD_W-1:0] LAST_COL = COORD_W'(((FRAME_WIDTH - 1) / 2) * 2);
  localparam logic [COORD_W-1:0] LAST_ROW = COORD_W'(((FRAME_HEIGHT - 1) / 2) * 2);

  // Offsets from the frame center in half pixels, and the datapath widths behind them.
  localparam int OFS_W   = COORD_W + 1;
  localparam int MAG_W   = OFS_W - 1;
  localparam int PROD1_W = MAG_W + FOV_W;
  localparam int PROD2_W = PROD1_W + Z_W;
  localparam int SUM_W   = PROD2_W + 1;
  localparam int RND_SH  = 25;
  localparam int RES_W   = SUM_W - RND_SH;

  localparam logic [FOV_W-1:0] FOV_RESET = FOV_W'(28953);
  localparam logic [RES_W-1:0] POS_LIMIT = RES_W'(65535);
  localparam logic [RES_W-1:0] NEG_LIMIT = RES_W'(65536);

  // Depth table constants. The angle is carried in Q0.40, depth in Q20 before rounding.
  localparam int DISP_DEPTH = 1 << DISP_W;
  localparam logic [DISP_W-1:0] INVALID_DISP = DISP_W'(2047);
  localparam longint PHI0     = 64'sd422758182148;
  localparam longint PHI_STEP = 64'sd386811479;
  localparam logic [63:0] K_INV   = 64'd142501097969406286;
  localparam logic [63:0] K_SCALE = 64'd1036832;
  localparam logic [63:0] K_OFS   = 64'd38797;

  typedef logic [Z_W-1:0] depth_lut_t [DISP_DEPTH];

  // Load enables of the three pipeline registers.
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } dpp_adv_t;

  // Restoring long division, used only while the depth table is built.
  function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Depth for one disparity: 0.1236*tan(d/2842.5 + 1.1863) - 0.037 in Q4.12, written as
  // 1/phi minus the odd series of cot, with phi the distance of the angle from the pole.
  function automatic logic [Z_W-1:0] depth_calc(input logic [DISP_W-1:0] d);
    longint      phi;
    logic [63:0] up;
    logic [63:0] inv;
    logic [63:0] q;
    logic [63:0] q2;
    logic [63:0] q3;
    logic [63:0] q5;
    logic [63:0] s;
    logic [63:0] corr;
    logic [63:0] z20;
    logic [63:0] z;
    logic [Z_W-1:0] res;
    res = '0;
    if (d != INVALID_DISP) begin
      phi = PHI0 - signed'({53'd0, d}) * PHI_STEP;
      if (phi > 0) begin
        up   = unsigned'(phi);
        inv  = long_div(K_INV, up);
        q    = up >> 10;
        q2   = (q * q) >> 30;
        q3   = (q2 * q) >> 30;
        q5   = (q3 * q2) >> 30;
        s    = q / 3 + q3 / 45 + (q5 * 2) / 945;
        corr = (s * K_SCALE) >> 33;
        if (inv > corr + K_OFS) begin
          z20 = inv - corr - K_OFS;
          z   = (z20 + 64'd128) >> 8;
          res = (z > 64'd65535) ? '1 : z[Z_W-1:0];
        end
      end
    end
    return res;
  endfunction

  function automatic depth_lut_t build_depth_lut();
    depth_lut_t lut;
    for (int i = 0; i < DISP_DEPTH; i++) begin
      lut[i] = depth_calc(DISP_W'(i));
    end
    return lut;
  endfunction

endpackage

FILE: src/dpp_depth_rom.sv
module dpp_depth_rom
  import dpp_pkg::*;
(
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [DISP_W-1:0] addr_i,
  output logic [Z_W-1:0]    data_o
);

  localparam depth_lut_t DepthLut = build_depth_lut();

  logic [Z_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= DepthLut[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

FILE: src/dpp_place.sv
module dpp_place
  import dpp_pkg::*;
(
  input  logic                    clk_i,
  input  dpp_adv_t                adv_i,
  input  logic signed [OFS_W-1:0] off_i,
  input  logic [FOV_W-1:0]        fov_i,
  input  logic [Z_W-1:0]          z_i,
  output logic [POS_W-1:0]        pos_o
);

  logic               neg;
  logic [OFS_W-1:0]   mag_full;
  logic [MAG_W-1:0]   mag;

  logic [PROD1_W-1:0] prod1_q;
  logic               neg1_q;
  logic [PROD2_W-1:0] prod2_q;
  logic               neg2_q;

  logic [SUM_W-1:0]   rnd_sum;
  logic [RES_W-1:0]   res;
  logic [POS_W-1:0]   pos_d;
  logic [POS_W-1:0]   pos_q;

  assign neg      = off_i[OFS_W-1];
  assign mag_full = neg ? unsigned'(-off_i) : unsigned'(off_i);
  assign mag      = mag_full[MAG_W-1:0];

  // Stage 1: offset times field of view. Stage 2: times depth.
  always_ff @(posedge clk_i) begin
    if (adv_i.ld1) begin
      prod1_q <= PROD1_W'(mag) * PROD1_W'(fov_i);
      neg1_q  <= neg;
    end
    if (adv_i.ld2) begin
      prod2_q <= PROD2_W'(prod1_q) * PROD2_W'(z_i);
      neg2_q  <= neg1_q;
    end
    if (adv_i.ld3) begin
      pos_q <= pos_d;
    end
  end

  // Stage 3: round the magnitude half up, which is away from zero for the signed value,
  // then saturate and restore the sign.
  assign rnd_sum = SUM_W'(prod2_q) + (SUM_W'(1) << (RND_SH - 1));
  assign res     = rnd_sum[SUM_W-1:RND_SH];

  always_comb begin
    if (neg2_q) begin
      if (res > NEG_LIMIT) begin
        pos_d = POS_W'(0) - POS_W'(NEG_LIMIT);
      end else begin
        pos_d = POS_W'(0) - res[POS_W-1:0];
      end
    end else begin
      if (res > POS_LIMIT) begin
        pos_d = POS_W'(POS_LIMIT);
      end else begin
        pos_d = res[POS_W-1:0];
      end
    end
  end

  assign pos_o = pos_q;

endmodule

FILE: src/depth_pixel_to_point.sv
// Depth pixel to 3D point converter.
// Input stream s_axis: one disparity pixel per request with its column and row, in
// raster order. Pixels on an odd row or an odd column are taken and dropped, so the
// frame is subsampled two to one in each direction.
// Output stream m_axis: one point per kept pixel, x and y and z in Q4.12 metres, with
// tlast set on the last kept pixel of the frame. A disparity of 2047 gives a zero point.
// Configuration: cfg_valid_i/cfg_data_i write the per-pixel field of view (Q0.24);
// cfg_ready_o is always high. Write it only while no pixel is in flight.
// An accepted pixel reaches its point on m_axis through the depth ROM read with the
// offset-times-fov multiply, the multiply by depth, then rounding into the output
// register. Throughput is one pixel per cycle while the receiver does not stall.
// Each stage holds its request while the one after it is full and stalled, so a stalled receiver
// holds the output register and the pipeline fills up behind it; bubbles are squeezed
// out, and s_axis_tready drops only when all three stages hold points.
// Reset empties the pipeline and loads the field of view with its default.
module depth_pixel_to_point
  import dpp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // Configuration write channel.
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [FOV_W-1:0] cfg_data_i,
  // Pixel stream.
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [31:0]      s_axis_tdata,  // disparity[10:0], column[20:11], row[29:21]
  // Point stream.
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [55:0]      m_axis_tdata,  // point_x[16:0], point_y[33:17], point_z[49:34]
  output logic             m_axis_tlast   // frame_end
);

  logic [DISP_W-1:0] disparity;
  logic [COL_W-1:0]  column;
  logic [ROW_W-1:0]  row;
  logic              keep;
  logic              last_pix;

  logic signed [OFS_W-1:0] off_x;
  logic signed [OFS_W-1:0] off_y;

  logic [FOV_W-1:0] fov_q;

  logic     v1_q, v2_q, v3_q;
  logic     last1_q, last2_q, last3_q;
  logic     rdy1, rdy2, rdy3;
  dpp_adv_t adv;

  logic [Z_W-1:0]   z1;
  logic [Z_W-1:0]   z2_q;
  logic [Z_W-1:0]   z3_q;
  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;

  assign disparity = s_axis_tdata[10:0];
  assign column    = s_axis_tdata[20:11];
  assign row       = s_axis_tdata[29:21];

  assign keep     = !column[0] && !row[0];
  assign last_pix = (COORD_W'(column) == LAST_COL) && (COORD_W'(row) == LAST_ROW);

  assign off_x = $signed({{(OFS_W - COL_W - 1){1'b0}}, column, 1'b0})
               - $signed(OFS_W'(FRAME_WIDTH));
  assign off_y = $signed(OFS_W'(FRAME_HEIGHT))
               - $signed({{(OFS_W - ROW_W - 1){1'b0}}, row, 1'b0});

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fov_q <= FOV_RESET;
    end else if (cfg_valid_i) begin
      fov_q <= cfg_data_i;
    end
  end

  // A stage loads when it is empty or the stage after it moves on.
  assign rdy3 = !v3_q || m_axis_tready;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign adv.ld1 = rdy1;
  assign adv.ld2 = rdy2;
  assign adv.ld3 = rdy3;

  assign s_axis_tready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= s_axis_tvalid && keep;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      last1_q <= last_pix;
    end
    if (rdy2) begin
      last2_q <= last1_q;
      z2_q    <= z1;
    end
    if (rdy3) begin
      last3_q <= last2_q;
      z3_q    <= z2_q;
    end
  end

  dpp_depth_rom u_depth_rom (
    .clk_i  (clk_i),
    .en_i   (rdy1),
    .addr_i (disparity),
    .data_o (z1)
  );

  dpp_place u_place_x (
    .clk_i (clk_i),
    .adv_i (adv),
    .off_i (off_x),
    .fov_i (fov_q),
    .z_i   (z1),
    .pos_o (pos_x)
  );

  dpp_place u_place_y (
    .clk_i (clk_i),
    .adv_i (adv),
    .off_i (off_y),
    .fov_i (fov_q),
    .z_i   (z1),
    .pos_o (pos_y)
  );

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = {6'd0, z3_q, pos_y, pos_x};
  assign m_axis_tlast  = last3_q;

  // A point at zero depth lies at the origin.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && z3_q == '0) |-> (pos_x == '0 && pos_y == '0))
    else $error("point at zero depth is off the origin");

  // Input back-pressure only comes from a full pipeline behind a stalled receiver.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (v1_q && v2_q && m_axis_tvalid && !m_axis_tready))
    else $error("input stalled with room in the pipeline");

  // A pixel on an odd row or column never enters the pipeline.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !keep) |=> !v1_q)
    else $error("dropped pixel entered the pipeline");

  // A point in the middle stage is not lost while the output is blocked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !rdy3) |=> (v2_q && $stable(z2_q)))
    else $error("middle stage changed while blocked");

endmodule
